@@ rtl/meb_pkg.sv @@
// Shared types, widths, codes and helpers for the escape-band pixel block.
// No dependencies; compile first.
`timescale 1ns / 1ps
package meb_pkg;

    localparam int CW     = 36;       // coordinate width, signed
    localparam int FB     = 28;       // fraction bits
    localparam int IW     = 12;       // row/col index width
    localparam int KW     = 16;       // step counter width
    localparam int SCW    = 24;       // scale width, Q8.16
    localparam int EW     = FB + 1;   // eps width
    localparam int PW     = 8;        // pixel width
    localparam int HW     = CW / 2;   // multiplier half operand
    localparam int SQW    = 2 * CW;   // square width
    localparam int WW     = SQW + 2;  // wide signed working width
    localparam int RW     = CW + 3;   // sqrt remainder width
    localparam int CFG_IW = 3;

    typedef logic signed [CW-1:0] t_coord;

    typedef enum logic [CFG_IW-1:0] {
        CFG_LEFT_RE  = 3'd0,
        CFG_TOP_IM   = 3'd1,
        CFG_STEP_RE  = 3'd2,
        CFG_STEP_IM  = 3'd3,
        CFG_EPS      = 3'd4,
        CFG_MAX_ITER = 3'd5,
        CFG_SCALE    = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        t_coord          left_re;
        t_coord          top_im;
        logic [CW-2:0]   step_re;
        logic [CW-2:0]   step_im;
        logic [EW-1:0]   eps;
        logic [KW-1:0]   max_iter;
        logic [SCW-1:0]  scale;
    } t_cfg;

    typedef struct packed {
        t_coord cre;
        t_coord cim;
    } t_cpoint;

    typedef enum logic [2:0] {
        ES_IDLE,
        ES_MUL,
        ES_SUM,
        ES_SQRT,
        ES_UPD,
        ES_GREY,
        ES_DONE
    } t_eng_state;

    // clamp a wide signed value to the coordinate range
    function automatic t_coord sat_coord(input logic signed [WW-1:0] v);
        logic signed [WW-1:0] hi;
        hi = v >>> (CW - 1);
        if (hi == '0 || hi == '1) begin
            return v[CW-1:0];
        end
        return v[WW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    endfunction

endpackage

@@ rtl/meb_req_if.sv @@
// Request channel: pixel row and column with valid/ready.
// Depends on meb_pkg.
`timescale 1ns / 1ps
interface meb_req_if;
    import meb_pkg::*;
    logic          valid;
    logic          ready;
    logic [IW-1:0] row;
    logic [IW-1:0] col;
    modport source (output valid, row, col, input ready);
    modport sink   (input valid, row, col, output ready);
endinterface

@@ rtl/meb_rsp_if.sv @@
// Response channel: one grey pixel with valid/ready.
// Depends on meb_pkg.
`timescale 1ns / 1ps
interface meb_rsp_if;
    import meb_pkg::*;
    logic          valid;
    logic          ready;
    logic [PW-1:0] pixel;
    modport source (output valid, pixel, input ready);
    modport sink   (input valid, pixel, output ready);
endinterface

@@ rtl/meb_front.sv @@
// Front end: takes a request and maps row/col to the point c.
// Depends on meb_pkg.
`timescale 1ns / 1ps
module meb_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  meb_pkg::t_cfg         i_cfg,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [meb_pkg::IW-1:0] i_row,
    input  logic [meb_pkg::IW-1:0] i_col,
    input  logic                  i_q_full,
    output logic                  o_q_push,
    output meb_pkg::t_cpoint      o_q_data
);
    import meb_pkg::*;

    logic                  r_s1v;
    logic [IW+CW-2:0]      r_prod_re;
    logic [IW+CW-2:0]      r_prod_im;
    logic signed [WW-1:0]  sum_re;
    logic signed [WW-1:0]  sum_im;

    assign o_ready  = !r_s1v;
    assign o_q_push = r_s1v && !i_q_full;

    always_comb begin
        sum_re = WW'(i_cfg.left_re) + $signed(WW'(r_prod_re));
        sum_im = WW'(i_cfg.top_im) - $signed(WW'(r_prod_im));
        o_q_data.cre = sat_coord(sum_re);
        o_q_data.cim = sat_coord(sum_im);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1v <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_s1v <= 1'b1;
        end else if (o_q_push) begin
            r_s1v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_prod_re <= i_col * i_cfg.step_re;
            r_prod_im <= i_row * i_cfg.step_im;
        end
    end

endmodule

@@ rtl/meb_queue.sv @@
// Short FIFO of points between front end and iteration engine.
// Depends on meb_pkg.
`timescale 1ns / 1ps
module meb_queue #(
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  meb_pkg::t_cpoint i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output meb_pkg::t_cpoint o_data
);
    import meb_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    t_cpoint         r_mem [DEPTH];
    logic [AW-1:0]   r_wp;
    logic [AW-1:0]   r_rp;
    logic [NW-1:0]   r_cnt;

    assign o_full  = (r_cnt == NW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + NW'(i_push) - NW'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

@@ rtl/meb_engine.sv @@
// Iteration engine: shared 36x18 multiplier, bit-serial square root,
// escape test and grey scaling, with a one-entry output register.
// Depends on meb_pkg.
`timescale 1ns / 1ps
module meb_engine (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  meb_pkg::t_cfg    i_cfg,
    input  logic             i_q_empty,
    input  meb_pkg::t_cpoint i_q_data,
    output logic             o_q_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [meb_pkg::PW-1:0] o_pixel
);
    import meb_pkg::*;

    t_eng_state r_state, n_state;

    t_coord            r_cre, r_cim, r_x, r_y;
    logic [KW-1:0]     r_k;
    logic [2:0]        r_step;
    logic              r_pp_v;
    logic [2:0]        r_pp_tag;
    logic [CW+HW-1:0]  r_pp;
    logic [SQW-1:0]    r_xx, r_yy, r_xy;
    logic [SQW-1:0]    r_rad;
    logic [RW-1:0]     r_rem;
    logic [CW-1:0]     r_root;
    logic [5:0]        r_cnt;
    logic [KW+SCW-1:0] r_gprod;
    logic [PW-1:0]     r_pix;
    logic              r_out_v;
    logic [PW-1:0]     r_out_pix;

    logic [CW-1:0]     ax, ay, mul_a, mul_b;
    logic [HW-1:0]     mul_h;
    logic [SQW-1:0]    acc_cur, acc_new;
    logic [RW-1:0]     rem_sh, trial;
    logic signed [WW-1:0] dxy, sxy, wx, wy;
    logic [KW-1:0]     k1;
    logic              hit, out_free;
    logic [SCW-1:0]    grey;

    // control outputs of the sequencer
    logic start, out_load;

    assign ax = r_x[CW-1] ? (~r_x + 1'b1) : r_x;
    assign ay = r_y[CW-1] ? (~r_y + 1'b1) : r_y;

    // products in order: x*x, y*y, x*y, low half of b first
    always_comb begin
        mul_a = (r_step[2:1] == 2'd1) ? ay : ax;
        mul_b = (r_step[2:1] == 2'd0) ? ax : ay;
        mul_h = r_step[0] ? mul_b[CW-1:HW] : mul_b[HW-1:0];
    end

    always_comb begin
        case (r_pp_tag[2:1])
            2'd0:    acc_cur = r_xx;
            2'd1:    acc_cur = r_yy;
            default: acc_cur = r_xy;
        endcase
        acc_new = r_pp_tag[0] ? acc_cur + (SQW'(r_pp) << HW) : SQW'(r_pp);
    end

    always_comb begin
        rem_sh = {r_rem[RW-3:0], r_rad[SQW-1:SQW-2]};
        trial  = RW'({r_root, 2'b01});
    end

    always_comb begin
        dxy = ($signed({2'b00, r_xx}) - $signed({2'b00, r_yy})) >>> FB;
        sxy = (r_x[CW-1] ^ r_y[CW-1]) ? -$signed({2'b00, r_xy}) : $signed({2'b00, r_xy});
        wx  = dxy + WW'(r_cre);
        wy  = (sxy >>> (FB - 1)) + WW'(r_cim);
        k1  = r_k + 1'b1;
        hit = r_root[CW-1] ||
              ((r_root[CW-2:FB+1] != '0) && (EW'(r_root[FB-1:0]) < i_cfg.eps));
        grey = r_gprod[KW+SCW-1:16];
    end

    assign out_free = !r_out_v || i_ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ES_IDLE: if (!i_q_empty) begin
                n_state = (i_cfg.max_iter == '0) ? ES_DONE : ES_MUL;
            end
            ES_MUL:  if (r_step == 3'd6) begin
                n_state = ES_SUM;
            end
            ES_SUM:  n_state = ES_SQRT;
            ES_SQRT: if (r_cnt == 6'(CW - 1)) begin
                n_state = ES_UPD;
            end
            ES_UPD: begin
                if (hit) begin
                    n_state = ES_GREY;
                end else if (k1 == i_cfg.max_iter) begin
                    n_state = ES_DONE;
                end else begin
                    n_state = ES_MUL;
                end
            end
            ES_GREY: n_state = ES_DONE;
            ES_DONE: if (out_free) begin
                n_state = ES_IDLE;
            end
            default: n_state = ES_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        start    = 1'b0;
        out_load = 1'b0;
        case (r_state)
            ES_IDLE: start = !i_q_empty;
            ES_DONE: out_load = out_free;
            default: ;
        endcase
    end

    assign o_q_pop = start;
    assign o_valid = r_out_v;
    assign o_pixel = r_out_pix;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ES_IDLE;
            r_out_v <= 1'b0;
            r_pp_v  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pp_v  <= (r_state == ES_MUL) && (r_step < 3'd6);
            if (out_load) begin
                r_out_v <= 1'b1;
            end else if (i_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_pix <= r_pix;
        end
        if (r_pp_v) begin
            case (r_pp_tag[2:1])
                2'd0:    r_xx <= acc_new;
                2'd1:    r_yy <= acc_new;
                default: r_xy <= acc_new;
            endcase
        end
        case (r_state)
            ES_IDLE: if (start) begin
                r_cre  <= i_q_data.cre;
                r_cim  <= i_q_data.cim;
                r_x    <= i_q_data.cre;
                r_y    <= i_q_data.cim;
                r_k    <= '0;
                r_step <= '0;
                r_pix  <= '0;
            end
            ES_MUL: begin
                r_pp     <= mul_a * mul_h;
                r_pp_tag <= r_step;
                if (r_step != 3'd6) begin
                    r_step <= r_step + 1'b1;
                end
            end
            ES_SUM: begin
                r_rad  <= r_xx + r_yy;
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= '0;
            end
            ES_SQRT: begin
                r_rad <= r_rad << 2;
                r_cnt <= r_cnt + 1'b1;
                if (rem_sh >= trial) begin
                    r_rem  <= rem_sh - trial;
                    r_root <= {r_root[CW-2:0], 1'b1};
                end else begin
                    r_rem  <= rem_sh;
                    r_root <= {r_root[CW-2:0], 1'b0};
                end
            end
            ES_UPD: begin
                r_x     <= sat_coord(wx);
                r_y     <= sat_coord(wy);
                r_k     <= k1;
                r_step  <= '0;
                r_gprod <= k1 * i_cfg.scale;
            end
            ES_GREY: begin
                r_pix <= (grey[SCW-1:PW] != '0) ? '1 : grey[PW-1:0];
            end
            default: ;
        endcase
    end

endmodule

@@ rtl/mandelbrot_escape_band_pixel.sv @@
// Top level of the escape-band pixel block: configuration registers,
// front end, point queue and iteration engine.
// Depends on meb_pkg, meb_req_if, meb_rsp_if, meb_front, meb_queue, meb_engine.
//
//   channel   dir  carries           handshake
//   i_req     in   row, col          valid/ready
//   o_rsp     out  pixel             valid/ready
//   cfg       in   idx, data         write enable, no wait
//
// Each iteration step runs the shared 36x18 multiplier (x*x, y*y, x*y in halves,
// then a drain step), forms |z|^2, runs the one-bit-per-cycle square root and
// updates z. On a hit a grey step follows before o_rsp.valid rises.
// Reset (synchronous, active low) empties the queue, idles both sides, loads the
// default view. A result waiting in o_rsp holds the engine; the front keeps
// filling the queue until it is full.
`timescale 1ns / 1ps
module mandelbrot_escape_band_pixel #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    meb_req_if.sink                   i_req,
    meb_rsp_if.source                 o_rsp,
    input  logic                      i_cfg_we,
    input  logic [meb_pkg::CFG_IW-1:0] i_cfg_idx,
    input  logic [meb_pkg::CW-1:0]    i_cfg_data
);
    import meb_pkg::*;

    t_cfg    r_cfg;
    logic    q_push, q_pop, q_full, q_empty;
    t_cpoint q_wdata, q_rdata;

    // configuration registers; write only while no request in flight (unchecked)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.left_re  <= -36'sd201326592;
            r_cfg.top_im   <= 36'sd27219078;
            r_cfg.step_re  <= 35'd3149;
            r_cfg.step_im  <= 35'd2936;
            r_cfg.eps      <= 29'd2684355;
            r_cfg.max_iter <= 16'd300;
            r_cfg.scale    <= 24'd55706;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_LEFT_RE:  r_cfg.left_re  <= i_cfg_data;
                CFG_TOP_IM:   r_cfg.top_im   <= i_cfg_data;
                CFG_STEP_RE:  r_cfg.step_re  <= i_cfg_data[CW-2:0];
                CFG_STEP_IM:  r_cfg.step_im  <= i_cfg_data[CW-2:0];
                CFG_EPS:      r_cfg.eps      <= i_cfg_data[EW-1:0];
                CFG_MAX_ITER: r_cfg.max_iter <= i_cfg_data[KW-1:0];
                CFG_SCALE:    r_cfg.scale    <= i_cfg_data[SCW-1:0];
                default: ;
            endcase
        end
    end

    // front end: c = (left + col*step_re, top - row*step_im), saturated
    meb_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (i_req.valid),
        .o_ready  (i_req.ready),
        .i_row    (i_req.row),
        .i_col    (i_req.col),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_q_data (q_wdata)
    );

    meb_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_rdata)
    );

    // back end: z iteration, escape test, grey value
    meb_engine u_engine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_empty (q_empty),
        .i_q_data  (q_rdata),
        .o_q_pop   (q_pop),
        .o_valid   (o_rsp.valid),
        .i_ready   (o_rsp.ready),
        .o_pixel   (o_rsp.pixel)
    );

endmodule

@@ rtl/meb_checker.sv @@
// Port-level checks for the escape-band pixel block, bound to the top level.
// Depends on meb_pkg and mandelbrot_escape_band_pixel.
`timescale 1ns / 1ps
module meb_checker (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_req_valid,
    input logic                   i_req_ready,
    input logic                   i_rsp_valid,
    input logic                   i_rsp_ready,
    input logic [meb_pkg::PW-1:0] i_rsp_pixel
);
    import meb_pkg::*;

    logic [7:0] r_open;
    logic       req_acc, rsp_acc;

    assign req_acc = i_req_valid && i_req_ready;
    assign rsp_acc = i_rsp_valid && i_rsp_ready;

    // requests taken and not yet answered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= '0;
        end else begin
            r_open <= r_open + 8'(req_acc) - 8'(rsp_acc);
        end
    end

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid)
        else $error("response dropped while stalled");

    a_pix_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> $stable(i_rsp_pixel))
        else $error("pixel changed while stalled");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("response valid right after reset");

    a_no_orphan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> r_open != '0)
        else $error("response without an open request");

endmodule

bind mandelbrot_escape_band_pixel meb_checker u_meb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_pixel (o_rsp.pixel)
);
